// File: hdl/slps_pkg.sv
package slps_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned LevelW    = 7;
  localparam int unsigned HueW      = 9;
  localparam int unsigned TimeWidthDefault = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLOW_PERIOD     = 3'd0,
    CFG_FAST_PERIOD     = 3'd1,
    CFG_FEEDBACK_PERIOD = 3'd2,
    CFG_FEEDBACK_DUR    = 3'd3,
    CFG_SATURATION      = 3'd4,
    CFG_BRIGHTNESS      = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EVT_NONE      = 2'd0,
    EVT_LOCKING   = 2'd1,
    EVT_UNLOCKING = 2'd2,
    EVT_FAIL      = 2'd3
  } fb_event_t;

  typedef enum logic [2:0] {
    VS_BOOTING       = 3'd0,
    VS_COMMISSIONING = 3'd1,
    VS_UNLOCKED      = 3'd2,
    VS_LOCKED        = 3'd3,
    VS_LOCKING       = 3'd4,
    VS_UNLOCKING     = 3'd5,
    VS_FAIL          = 3'd6
  } vstate_t;

  localparam logic [PeriodW-1:0] SLOW_PERIOD_RST     = 16'd500;
  localparam logic [PeriodW-1:0] FAST_PERIOD_RST     = 16'd200;
  localparam logic [PeriodW-1:0] FEEDBACK_PERIOD_RST = 16'd150;
  localparam logic [PeriodW-1:0] FEEDBACK_DUR_RST    = 16'd2000;
  localparam logic [LevelW-1:0]  SATURATION_RST      = 7'd100;
  localparam logic [LevelW-1:0]  BRIGHTNESS_RST      = 7'd10;
  localparam logic [LevelW-1:0]  LEVEL_MAX           = 7'd100;

  localparam logic [HueW-1:0] HUE_BLUE   = 9'd240;
  localparam logic [HueW-1:0] HUE_GREEN  = 9'd120;
  localparam logic [HueW-1:0] HUE_ORANGE = 9'd30;
  localparam logic [HueW-1:0] HUE_RED    = 9'd0;

  function automatic logic [LevelW-1:0] cap100(input logic [LevelW-1:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

endpackage

// File: hdl/status_led_pattern_selector_top.sv
// Status LED pattern selector. Each accepted input item is one millisecond tick
// and yields exactly one result item, registered in the following cycle, holding
// the visual state and the LED frame (on/off, hue, saturation, brightness) for
// that tick. A new item can be accepted every clock cycle: the three blink
// counters and the override timer update once per accepted tick, and the
// output register takes a new result whenever it is empty or being read in
// the same cycle. Blink phases start at reset and advance only on accepted
// ticks. Configuration writes are always ready; indexes 0 to 5 select slow,
// fast and feedback blink half-periods, feedback duration, saturation and
// brightness, other indexes are ignored.
module status_led_pattern_selector_top #(
  parameter int unsigned TIME_WIDTH = slps_pkg::TimeWidthDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_system_ready,
  input  logic                          in_commissioning_open,
  input  logic                          in_door_locked,
  input  logic [1:0]                    in_feedback_event,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_visual_state,
  output logic                          out_led_on,
  output logic [slps_pkg::HueW-1:0]     out_hue_degrees,
  output logic [slps_pkg::LevelW-1:0]   out_saturation_out,
  output logic [slps_pkg::LevelW-1:0]   out_brightness_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [slps_pkg::CfgDataW-1:0] cfg_data
);
  import slps_pkg::*;

  logic [PeriodW-1:0] slow_period_r, fast_period_r, fb_period_r, fb_dur_r;
  logic [LevelW-1:0]  sat_level_r, bright_level_r;

  logic               accept;
  logic               slow_lit, fast_lit, fb_lit;
  logic [1:0]         ovr_kind;
  vstate_t            vstate;
  logic               lit;
  logic [HueW-1:0]    hue;
  logic [LevelW-1:0]  bright;

  logic               out_valid_r;
  vstate_t            vstate_r;
  logic               led_on_r;
  logic [HueW-1:0]    hue_r;
  logic [LevelW-1:0]  sat_r, bright_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_period_r  <= SLOW_PERIOD_RST;
      fast_period_r  <= FAST_PERIOD_RST;
      fb_period_r    <= FEEDBACK_PERIOD_RST;
      fb_dur_r       <= FEEDBACK_DUR_RST;
      sat_level_r    <= SATURATION_RST;
      bright_level_r <= BRIGHTNESS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SLOW_PERIOD:     slow_period_r  <= cfg_data;
        CFG_FAST_PERIOD:     fast_period_r  <= cfg_data;
        CFG_FEEDBACK_PERIOD: fb_period_r    <= cfg_data;
        CFG_FEEDBACK_DUR:    fb_dur_r       <= cfg_data;
        CFG_SATURATION:      sat_level_r    <= cfg_data[LevelW-1:0];
        CFG_BRIGHTNESS:      bright_level_r <= cfg_data[LevelW-1:0];
        default: ;
      endcase
    end
  end

  slps_period_ctr #(.TIME_WIDTH(TIME_WIDTH)) u_slow_ctr (
    .clk(clk), .rst_n(rst_n), .advance(accept), .period(slow_period_r), .lit(slow_lit)
  );

  slps_period_ctr #(.TIME_WIDTH(TIME_WIDTH)) u_fast_ctr (
    .clk(clk), .rst_n(rst_n), .advance(accept), .period(fast_period_r), .lit(fast_lit)
  );

  slps_period_ctr #(.TIME_WIDTH(TIME_WIDTH)) u_fb_ctr (
    .clk(clk), .rst_n(rst_n), .advance(accept), .period(fb_period_r), .lit(fb_lit)
  );

  slps_override #(.TIME_WIDTH(TIME_WIDTH)) u_override (
    .clk(clk), .rst_n(rst_n), .advance(accept), .fb_event(in_feedback_event),
    .duration(fb_dur_r), .kind(ovr_kind)
  );

  always_comb begin
    if (ovr_kind != EVT_NONE) begin
      vstate = vstate_t'(3'(ovr_kind) + 3'(VS_LOCKED));
    end else if (!in_system_ready) begin
      vstate = VS_BOOTING;
    end else if (in_commissioning_open) begin
      vstate = VS_COMMISSIONING;
    end else begin
      vstate = in_door_locked ? VS_LOCKED : VS_UNLOCKED;
    end
  end

  always_comb begin
    unique case (vstate)
      VS_BOOTING: begin
        lit = slow_lit;
        hue = HUE_BLUE;
      end
      VS_COMMISSIONING: begin
        lit = fast_lit;
        hue = HUE_BLUE;
      end
      VS_UNLOCKED: begin
        lit = 1'b1;
        hue = HUE_GREEN;
      end
      VS_LOCKED: begin
        lit = 1'b1;
        hue = HUE_ORANGE;
      end
      VS_LOCKING: begin
        lit = fb_lit;
        hue = HUE_ORANGE;
      end
      VS_UNLOCKING: begin
        lit = fb_lit;
        hue = HUE_GREEN;
      end
      default: begin
        lit = fb_lit;
        hue = HUE_RED;
      end
    endcase
  end

  assign bright = cap100(bright_level_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vstate_r <= vstate;
      led_on_r <= lit && (bright != '0);
      hue_r    <= hue;
      sat_r    <= cap100(sat_level_r);
      bright_r <= bright;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_visual_state   = vstate_r;
  assign out_led_on         = led_on_r;
  assign out_hue_degrees    = hue_r;
  assign out_saturation_out = sat_r;
  assign out_brightness_out = bright_r;

endmodule

// File: hdl/slps_period_ctr.sv
module slps_period_ctr #(
  parameter int unsigned TIME_WIDTH = slps_pkg::TimeWidthDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [slps_pkg::PeriodW-1:0] period,
  output logic                         lit
);
  import slps_pkg::*;

  localparam int unsigned CW = (TIME_WIDTH + 1 > PeriodW + 1) ? TIME_WIDTH + 1 : PeriodW + 1;

  logic [TIME_WIDTH-1:0] count_r, count_nxt;
  logic                  phase_off_r, phase_off_nxt;
  logic [CW-1:0]         sum;
  logic [CW-1:0]         wrapped;
  logic [CW-1:0]         period_ext;
  logic                  period_zero;

  assign period_zero = (period == '0);
  assign period_ext  = CW'(period);
  assign sum         = CW'(count_r) + CW'(1);
  assign wrapped     = CW'(sum[TIME_WIDTH-1:0]);
  assign lit         = period_zero || !phase_off_r;

  always_comb begin
    count_nxt     = count_r;
    phase_off_nxt = phase_off_r;
    if (period_zero) begin
      count_nxt     = '0;
      phase_off_nxt = 1'b0;
    end else if (wrapped >= period_ext || sum >= period_ext) begin
      count_nxt     = '0;
      phase_off_nxt = !phase_off_r;
    end else begin
      count_nxt = sum[TIME_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      phase_off_r <= 1'b0;
    end else if (advance) begin
      count_r     <= count_nxt;
      phase_off_r <= phase_off_nxt;
    end
  end

endmodule

// File: hdl/slps_override.sv
module slps_override #(
  parameter int unsigned TIME_WIDTH = slps_pkg::TimeWidthDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [1:0]                   fb_event,
  input  logic [slps_pkg::PeriodW-1:0] duration,
  output logic [1:0]                   kind
);
  import slps_pkg::*;

  localparam int unsigned DW = (TIME_WIDTH > PeriodW) ? TIME_WIDTH : PeriodW;

  logic [1:0]            kind_r, kind_nxt;
  logic [TIME_WIDTH-1:0] left_r, left_nxt;
  logic [TIME_WIDTH-1:0] left_cur;
  logic [TIME_WIDTH-1:0] left_dec;
  logic [1:0]            kind_load;
  logic [DW-1:0]         dur_ext;

  assign dur_ext = DW'(duration);

  always_comb begin
    if (fb_event != EVT_NONE) begin
      kind_load = fb_event;
      left_cur  = dur_ext[TIME_WIDTH-1:0];
    end else begin
      kind_load = kind_r;
      left_cur  = left_r;
    end
    kind     = (left_cur == '0) ? EVT_NONE : kind_load;
    left_dec = left_cur - TIME_WIDTH'(1);
    if (kind != EVT_NONE) begin
      left_nxt = left_dec;
      kind_nxt = (left_dec == '0) ? EVT_NONE : kind;
    end else begin
      left_nxt = left_cur;
      kind_nxt = EVT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= EVT_NONE;
      left_r <= '0;
    end else if (advance) begin
      kind_r <= kind_nxt;
      left_r <= left_nxt;
    end
  end

endmodule
